// ===== hw/rtl/rsd_pkg.sv =====
`timescale 1ns / 1ps

package rsd_pkg;

  // request codes
  localparam logic REQ_MEAS = 1'b0;
  localparam logic REQ_CAL  = 1'b1;

  localparam int ADC_W = 10;
  localparam int POT_W = 8;
  localparam int RD_W  = 20;
  localparam int R_W   = 30;
  localparam int DL_W  = 32;
  localparam int MAG_W = 31;
  localparam int BAR_W = 16;

  localparam logic [ADC_W-1:0] ADC_FULL    = 10'd1023;
  localparam logic [POT_W-1:0] POT_STEPS   = 8'd255;
  localparam logic [13:0]      DELTA_SCALE = 14'd10000;
  localparam logic [5:0]       BAR_GAIN    = 6'd60;
  localparam logic [R_W-1:0]   R_SAT       = 30'h3FFF_FFFF;
  localparam logic [MAG_W-1:0] DELTA_MAX   = 31'h7FFF_FFFF;
  localparam logic [BAR_W-1:0] BAR_MAX     = 16'hFFFF;
  localparam logic [RD_W-1:0]  POT_RESET   = 20'd100000;

  // serial divider: dividend width and quotient bits per division
  localparam int DVD_W = 44;
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] NB_R   = 6'd30;
  localparam logic [CNT_W-1:0] NB_MAG = 6'd44;
  localparam logic [CNT_W-1:0] NB_BAR = 6'd36;

  typedef struct packed {
    logic             req_type;
    logic [2:0]       channel;
    logic [ADC_W-1:0] adc_code;
    logic [POT_W-1:0] pot_code;
  } req_t;

  typedef struct packed {
    logic [R_W-1:0]         resistance_ohms;
    logic signed [DL_W-1:0] delta_e4;
    logic [BAR_W-1:0]       bar_extent;
    logic                   bar_down;
    logic                   changed;
    logic                   fault;
  } res_t;

  typedef struct packed {
    logic [RD_W-1:0] divider_ohms;
    logic [R_W-1:0]  baseline_ohms;
    logic [DL_W-1:0] last_delta;
  } entry_t;

endpackage

// ===== hw/rtl/rsd_if.sv =====
`timescale 1ns / 1ps

interface rsd_req_if;
  logic          valid;
  logic          ready;
  rsd_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsd_res_if;
  logic          valid;
  logic          ready;
  rsd_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [rsd_pkg::RD_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/resistive_sensor_delta.sv =====
`timescale 1ns / 1ps
// a full-scale reading skips the resistance division on measure and calibrate; a bad channel
// goes straight to a faulted result; one word at a time, the next taken once the result is
// registered and the FSM is idle again; paced by the shared bit-serial divider, one quotient
// bit a cycle (30 bits on calibrate after a reciprocal multiply for the divider, up to 30+44+36
// on measure); a waiting result holds back only the write-back of the next word
// reset: asynchronous, pot_full_ohms back to 100000, all channel entries read as zero
module resistive_sensor_delta #(
  parameter int CHANNELS = 5
) (
  input logic         clk_i,
  input logic         rst_ni,
  rsd_cfg_if.sink     cfg_i,
  rsd_req_if.sink     req_i,
  rsd_res_if.source   res_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DW = rsd_pkg::DVD_W;
  localparam int CW = rsd_pkg::CNT_W;
  localparam int RW = rsd_pkg::R_W;
  localparam int BW = rsd_pkg::BAR_W;
  localparam int MW = rsd_pkg::MAG_W;
  localparam int LW = rsd_pkg::DL_W;
  localparam int DR = rsd_pkg::RD_W;
  localparam int PW = rsd_pkg::POT_W + rsd_pkg::RD_W;
  localparam int SW = PW + 29;
  localparam int RCP_SH = 36;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RECIP, S_DIV, S_POST, S_DELTA, S_SCALE, S_DONE
  } state_e;

  typedef enum logic [1:0] {P_RD, P_R, P_MAG, P_BAR} phase_e;

  state_e state_q;
  phase_e phase_q;

  rsd_pkg::req_t   req_q;
  logic            ch_ok_q;
  logic [DR-1:0]   pot_full_q;
  logic [DR-1:0]   rd_q;
  logic [RW-1:0]   r_q;
  logic [RW-1:0]   num_q;
  logic [MW-1:0]   mag_q;
  logic [BW-1:0]   bar_q;
  logic            down_q;
  logic            fault_q;
  logic [DW-1:0]   dvd_q;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   dsr_q;
  logic [CW-1:0]   cnt_q;
  rsd_pkg::res_t   res_q;
  logic            res_vld_q;

  // channel store
  rsd_pkg::entry_t mem [CHANNELS];
  rsd_pkg::entry_t rdata_q;
  logic            rvld_q;
  logic [CHANNELS-1:0] vld_q;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;
  rsd_pkg::entry_t wr_ent;
  rsd_pkg::entry_t rd_ent;

  logic            in_fire;
  logic            in_range;
  logic            is_cal;
  logic            adc_full;
  logic [rsd_pkg::ADC_W-1:0] adc_gap;
  logic            out_free;
  logic            res_load;

  logic            st_go;
  phase_e          st_ph;
  logic [RW-1:0]   mul_a;
  logic [DR-1:0]   mul_b;
  logic [RW-1:0]   st_dsr;
  logic [CW-1:0]   st_nb;
  logic [RW+DR-1:0] prod;

  logic [SW-1:0]   rcp_x;
  logic [SW-1:0]   rcp_sum;

  logic [RW:0]     trial;
  logic [RW:0]     diff;
  logic            take;
  logic [RW-1:0]   rem_nx;
  logic [DW-1:0]   dvd_nx;

  logic [RW-1:0]   r0;
  logic            r_ge;
  logic [LW-1:0]   dbits;
  rsd_pkg::res_t   res_c;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign in_range    = int'(req_i.data.channel) < CHANNELS;

  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  assign is_cal   = (req_q.req_type == rsd_pkg::REQ_CAL);
  assign adc_full = (req_q.adc_code == rsd_pkg::ADC_FULL);
  assign adc_gap  = rsd_pkg::ADC_FULL - req_q.adc_code;
  assign out_free = !res_vld_q || res_o.ready;
  assign res_load = (state_q == S_DONE) && out_free;

  // never-written entries read as zero
  assign rd_ent  = rvld_q ? rdata_q : '0;
  assign rd_en   = in_fire && in_range;
  assign rd_addr = AW'(req_i.data.channel);
  assign wr_addr = AW'(req_q.channel);
  assign mem_we  = (state_q == S_DONE) && out_free && ch_ok_q;

  // entries are read at acceptance and written back when the result leaves, one word
  // at a time, so read and write of the same entry never overlap
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_full_q <= rsd_pkg::POT_RESET;
    end else if (cfg_i.valid) begin
      pot_full_q <= cfg_i.data;
    end
  end

  // restoring divider step
  assign trial  = {rem_q, dvd_q[DW-1]};
  assign take   = trial >= {1'b0, dsr_q};
  assign diff   = trial - {1'b0, dsr_q};
  assign rem_nx = take ? diff[RW-1:0] : trial[RW-1:0];
  assign dvd_nx = {dvd_q[DW-2:0], take};

  assign prod = {{DR{1'b0}}, mul_a} * {{RW{1'b0}}, mul_b};

  // divide by 255 as a multiply by 0x10101011 and a shift by 36, exact below 2^28
  assign rcp_x   = SW'(dvd_q[PW-1:0]);
  assign rcp_sum = ((rcp_x << 28) + (rcp_x << 20)) + ((rcp_x << 12) + (rcp_x << 4)) + rcp_x;

  // operands for the next division
  always_comb begin
    st_go  = 1'b0;
    st_ph  = P_RD;
    mul_a  = '0;
    mul_b  = '0;
    st_dsr = '0;
    st_nb  = '0;
    case (state_q)
      S_LOAD: begin
        if (is_cal) begin
          mul_a  = RW'(req_q.pot_code);
          mul_b  = pot_full_q;
        end else if (!adc_full) begin
          st_go  = 1'b1;
          st_ph  = P_R;
          mul_a  = RW'(req_q.adc_code);
          mul_b  = rd_ent.divider_ohms;
          st_dsr = RW'(adc_gap);
          st_nb  = rsd_pkg::NB_R;
        end
      end
      S_POST: begin
        case (phase_q)
          P_RD: begin
            if (!adc_full) begin
              st_go  = 1'b1;
              st_ph  = P_R;
              mul_a  = RW'(req_q.adc_code);
              mul_b  = dvd_q[DR-1:0];
              st_dsr = RW'(adc_gap);
              st_nb  = rsd_pkg::NB_R;
            end
          end
          P_MAG: begin
            st_go  = 1'b1;
            st_ph  = P_BAR;
            mul_a  = num_q;
            mul_b  = DR'(rsd_pkg::BAR_GAIN);
            st_dsr = dsr_q;
            st_nb  = rsd_pkg::NB_BAR;
          end
          default: ;
        endcase
      end
      S_SCALE: begin
        st_go  = 1'b1;
        st_ph  = P_MAG;
        mul_a  = num_q;
        mul_b  = DR'(rsd_pkg::DELTA_SCALE);
        st_dsr = dsr_q;
        st_nb  = rsd_pkg::NB_MAG;
      end
      default: ;
    endcase
  end

  assign r0   = rd_ent.baseline_ohms;
  assign r_ge = r_q >= r0;

  always_comb begin
    dbits = down_q ? (LW'(0) - LW'(mag_q)) : LW'(mag_q);
    res_c.resistance_ohms = r_q;
    res_c.delta_e4        = dbits;
    res_c.bar_extent      = bar_q;
    res_c.bar_down        = down_q;
    res_c.changed         = !is_cal && ch_ok_q && (dbits != rd_ent.last_delta);
    res_c.fault           = fault_q;
    wr_ent.divider_ohms   = rd_q;
    if (is_cal) begin
      wr_ent.baseline_ohms = r_q;
      wr_ent.last_delta    = rd_ent.last_delta;
    end else begin
      wr_ent.baseline_ohms = r0;
      wr_ent.last_delta    = dbits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= P_RD;
      req_q     <= '0;
      ch_ok_q   <= 1'b0;
      rd_q      <= '0;
      r_q       <= '0;
      num_q     <= '0;
      mag_q     <= '0;
      bar_q     <= '0;
      down_q    <= 1'b0;
      fault_q   <= 1'b0;
      dvd_q     <= '0;
      rem_q     <= '0;
      dsr_q     <= '0;
      cnt_q     <= '0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      if (res_o.ready && !res_load) begin
        res_vld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            req_q   <= req_i.data;
            ch_ok_q <= in_range;
            r_q     <= '0;
            mag_q   <= '0;
            bar_q   <= '0;
            down_q  <= 1'b0;
            fault_q <= !in_range;
            state_q <= in_range ? S_LOAD : S_DONE;
          end
        end
        S_LOAD: begin
          rd_q <= rd_ent.divider_ohms;
          if (is_cal) begin
            dvd_q   <= prod[DW-1:0];
            state_q <= S_RECIP;
          end else if (adc_full) begin
            r_q     <= rsd_pkg::R_SAT;
            fault_q <= 1'b1;
            state_q <= S_DELTA;
          end
        end
        S_RECIP: begin
          dvd_q   <= DW'(rcp_sum[SW-1:RCP_SH]);
          phase_q <= P_RD;
          state_q <= S_POST;
        end
        S_DIV: begin
          dvd_q <= dvd_nx;
          rem_q <= rem_nx;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          case (phase_q)
            P_RD: begin
              rd_q <= dvd_q[DR-1:0];
              if (adc_full) begin
                r_q     <= rsd_pkg::R_SAT;
                fault_q <= 1'b1;
                state_q <= S_DONE;
              end
            end
            P_R: begin
              r_q     <= (dvd_q > DW'(rsd_pkg::R_SAT)) ? rsd_pkg::R_SAT : dvd_q[RW-1:0];
              state_q <= is_cal ? S_DONE : S_DELTA;
            end
            P_MAG: begin
              mag_q <= (dvd_q > DW'(rsd_pkg::DELTA_MAX)) ? rsd_pkg::DELTA_MAX : dvd_q[MW-1:0];
            end
            P_BAR: begin
              bar_q   <= (dvd_q > DW'(rsd_pkg::BAR_MAX)) ? rsd_pkg::BAR_MAX : dvd_q[BW-1:0];
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_DELTA: begin
          if (r0 == '0) begin
            // no baseline
            fault_q <= 1'b1;
            mag_q   <= rsd_pkg::DELTA_MAX;
            bar_q   <= rsd_pkg::BAR_MAX;
            state_q <= S_DONE;
          end else if (r_ge) begin
            num_q   <= r_q - r0;
            dsr_q   <= r0;
            state_q <= S_SCALE;
          end else begin
            down_q <= 1'b1;
            if (r_q == '0) begin
              fault_q <= 1'b1;
              mag_q   <= rsd_pkg::DELTA_MAX;
              bar_q   <= rsd_pkg::BAR_MAX;
              state_q <= S_DONE;
            end else begin
              num_q   <= r0 - r_q;
              dsr_q   <= r_q;
              state_q <= S_SCALE;
            end
          end
        end
        // divider start below
        S_SCALE: ;
        S_DONE: begin
          if (out_free) begin
            res_q     <= res_c;
            res_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // load product and divisor, dividend left-aligned to the quotient width
      if (st_go) begin
        dvd_q   <= prod[DW-1:0] << (CW'(DW) - st_nb);
        rem_q   <= '0;
        dsr_q   <= st_dsr;
        cnt_q   <= st_nb;
        phase_q <= st_ph;
        state_q <= S_DIV;
      end
    end
  end

  a_wb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_DONE) && ch_ok_q)
    else $error("channel store written outside write-back or for a bad channel");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q != '0))
    else $error("divider running with no quotient bits left");

  a_down_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.bar_down) |-> (res_q.delta_e4[LW-1] || (res_q.delta_e4 == '0)))
    else $error("downward bar with positive delta");

  a_cal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(res_vld_q) && $past(is_cal)) |-> !res_q.changed && !res_q.bar_down)
    else $error("calibrate word reports a change");

endmodule
